### hdl/vks_pkg.sv
// Shared types, constants and helper functions for the vehicle kinematic step block.
// Used by vks_ctrl, vks_dp and vehicle_kinematic_step; depends on nothing else.
package vks_pkg;

    localparam logic [24:0] DEG90  = 25'd5898240;
    localparam logic [24:0] DEG180 = 25'd11796480;
    localparam logic [24:0] DEG360 = 25'd23592960;
    localparam int unsigned CORDIC_STEPS = 20;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [15:0] DEADBAND = 16'sd25;
    localparam int unsigned RED_STEPS = 8;

    localparam logic [7:0] REG_SPEED_MIN = 8'd0;
    localparam logic [7:0] REG_SPEED_MAX = 8'd1;
    localparam logic [7:0] REG_STEER_MIN = 8'd2;
    localparam logic [7:0] REG_STEER_MAX = 8'd3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SD, ST_CORD, ST_MX0, ST_MX1, ST_MZ0, ST_MZ1, ST_MDH, ST_HSUM,
        ST_RED, ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_SD, OP_CORD, OP_X0, OP_X1, OP_Z0, OP_Z1, OP_DH,
        OP_HSUM, OP_RED, OP_DONE
    } op_t;

    typedef enum logic [1:0] {
        MODE_KEEP, MODE_HIGH, MODE_LOW
    } mode_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] iter;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    function automatic logic signed [26:0] atan_deg(input logic [4:0] i);
        logic signed [26:0] r;
        unique case (i)
            5'd0:  r = 27'sd2949120;
            5'd1:  r = 27'sd1740967;
            5'd2:  r = 27'sd919879;
            5'd3:  r = 27'sd466945;
            5'd4:  r = 27'sd234379;
            5'd5:  r = 27'sd117304;
            5'd6:  r = 27'sd58666;
            5'd7:  r = 27'sd29335;
            5'd8:  r = 27'sd14668;
            5'd9:  r = 27'sd7334;
            5'd10: r = 27'sd3667;
            5'd11: r = 27'sd1833;
            5'd12: r = 27'sd917;
            5'd13: r = 27'sd458;
            5'd14: r = 27'sd229;
            5'd15: r = 27'sd115;
            5'd16: r = 27'sd57;
            5'd17: r = 27'sd29;
            5'd18: r = 27'sd14;
            5'd19: r = 27'sd7;
            default: r = 27'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### hdl/vks_ctrl.sv
// Sequencer for the kinematic step: walks load, multiply, CORDIC, heading wrap and output.
// Depends on vks_pkg; drives vks_dp through cmd_t and reads status_t.
module vks_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  vks_pkg::status_t status,
    output vks_pkg::cmd_t    cmd
);
    import vks_pkg::*;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        cmd.iter   = cnt_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_SD;
                end
            end
            ST_SD: begin
                cmd.op     = OP_SD;
                cnt_next   = '0;
                state_next = ST_CORD;
            end
            ST_CORD: begin
                cmd.op = OP_CORD;
                if (cnt_reg == 5'(CORDIC_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_MX0;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_MX0: begin
                cmd.op     = OP_X0;
                state_next = ST_MX1;
            end
            ST_MX1: begin
                cmd.op     = OP_X1;
                state_next = ST_MZ0;
            end
            ST_MZ0: begin
                cmd.op     = OP_Z0;
                state_next = ST_MZ1;
            end
            ST_MZ1: begin
                cmd.op     = OP_Z1;
                state_next = ST_MDH;
            end
            ST_MDH: begin
                cmd.op     = OP_DH;
                state_next = ST_HSUM;
            end
            ST_HSUM: begin
                cmd.op     = OP_HSUM;
                cnt_next   = '0;
                state_next = ST_RED;
            end
            ST_RED: begin
                cmd.op = OP_RED;
                if (cnt_reg == 5'(RED_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.op     = OP_DONE;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SD))
        else $error("accepted beat did not start the sequence");

    a_cordic_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CORD) |-> (cnt_reg < 5'(CORDIC_STEPS)))
        else $error("CORDIC iteration count out of range");

endmodule

### hdl/vks_dp.sv
// Datapath for the kinematic step: limits, state, shared multiplier, CORDIC, heading wrap.
// Depends on vks_pkg; sequenced by vks_ctrl through cmd_t.
module vks_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  vks_pkg::cmd_t       cmd,
    output vks_pkg::status_t    status,
    input  logic                cfg_valid,
    input  logic [7:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic signed [15:0]  s_speed_cmd,
    input  logic signed [15:0]  s_steer_cmd,
    input  logic [15:0]         s_time_step,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_pos_x,
    output logic signed [31:0]  m_pos_z,
    output logic [24:0]         m_heading_out,
    output logic signed [31:0]  m_dist_out,
    output logic signed [15:0]  m_speed_out,
    output logic signed [15:0]  m_steer_out
);
    import vks_pkg::*;

    logic signed [15:0] speed_min_reg, steer_min_reg;
    logic [14:0]        speed_max_reg, steer_max_reg;
    logic signed [31:0] x_pos_reg, z_pos_reg, travelled_reg;
    logic [24:0]        heading_reg;
    logic               m_valid_reg;

    logic signed [15:0] spd_reg, str_reg;
    logic [15:0]        dt_reg;
    logic signed [32:0] sd_reg;
    logic signed [51:0] p_reg;
    logic signed [67:0] ax_reg, az_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [26:0] ca_reg;
    logic               neg_reg;
    logic [31:0]        u_reg;
    mode_t              mode_reg;

    // clamp, upper limit first
    logic signed [16:0] spd_c, str_c;
    always_comb begin
        spd_c = 17'(s_speed_cmd);
        if (spd_c > $signed({2'b00, speed_max_reg})) spd_c = $signed({2'b00, speed_max_reg});
        if (spd_c < 17'(speed_min_reg)) spd_c = 17'(speed_min_reg);
        str_c = 17'(s_steer_cmd);
        if (str_c > $signed({2'b00, steer_max_reg})) str_c = $signed({2'b00, steer_max_reg});
        if (str_c < 17'(steer_min_reg)) str_c = 17'(steer_min_reg);
    end

    // fold heading into -90..90
    logic signed [26:0] a0, af;
    logic               fneg;
    always_comb begin
        a0 = $signed({2'b00, heading_reg});
        if (heading_reg > DEG180) a0 = a0 - $signed({2'b00, DEG360});
        af   = a0;
        fneg = 1'b0;
        if (a0 > $signed({2'b00, DEG90})) begin
            af   = a0 - $signed({2'b00, DEG180});
            fneg = 1'b1;
        end else if (a0 < -$signed({2'b00, DEG90})) begin
            af   = a0 + $signed({2'b00, DEG180});
            fneg = 1'b1;
        end
    end

    logic signed [33:0] xs, ys, cos_v, sin_v;
    logic signed [26:0] atn;
    assign xs    = cx_reg >>> cmd.iter;
    assign ys    = cy_reg >>> cmd.iter;
    assign atn   = atan_deg(cmd.iter);
    assign cos_v = neg_reg ? -cx_reg : cx_reg;
    assign sin_v = neg_reg ? -cy_reg : cy_reg;

    // shared multiplier
    logic signed [33:0] ma;
    logic signed [17:0] mb;
    logic signed [51:0] prod;
    always_comb begin
        ma = '0;
        mb = '0;
        unique case (cmd.op)
            OP_SD: begin
                ma = 34'(spd_reg);
                mb = $signed({2'b00, dt_reg});
            end
            OP_X0: begin
                ma = cos_v;
                mb = $signed({2'b00, sd_reg[15:0]});
            end
            OP_X1: begin
                ma = cos_v;
                mb = $signed({sd_reg[32], sd_reg[32:16]});
            end
            OP_Z0: begin
                ma = sin_v;
                mb = $signed({2'b00, sd_reg[15:0]});
            end
            OP_Z1: begin
                ma = sin_v;
                mb = $signed({sd_reg[32], sd_reg[32:16]});
            end
            OP_DH: begin
                ma = 34'(sd_reg);
                mb = 18'(str_reg);
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end
    assign prod = ma * mb;

    // heading sum, position and distance updates
    logic signed [32:0] dh;
    logic signed [33:0] hv, xsum, zsum, dsum;
    logic signed [67:0] xr, zr;
    logic signed [32:0] sd_db, dinc;
    logic               spd_dead, str_dead;
    logic [31:0]        u_new;
    mode_t              mode_new;
    always_comb begin
        dh   = 33'((p_reg + 52'sd32768) >>> 16);
        hv   = $signed({9'd0, heading_reg}) + 34'(dh);
        xr   = (ax_reg + (68'sd1 <<< 37)) >>> 38;
        zr   = (az_reg + (68'sd1 <<< 37)) >>> 38;
        xsum = 34'(x_pos_reg) + 34'(xr);
        zsum = 34'(z_pos_reg) + 34'(zr);
        spd_dead = (spd_reg >= -DEADBAND) && (spd_reg <= DEADBAND);
        str_dead = (str_reg >= -DEADBAND) && (str_reg <= DEADBAND);
        sd_db = spd_dead ? 33'sd0 : sd_reg;
        dinc  = (sd_db + 33'sd128) >>> 8;
        dsum  = 34'(travelled_reg) + 34'(dinc);
        if (hv > $signed({9'd0, DEG360})) begin
            mode_new = MODE_HIGH;
            u_new    = 32'(hv - 34'sd1);
        end else if (hv < 34'sd0) begin
            mode_new = MODE_LOW;
            u_new    = 32'(-34'sd1 - hv);
        end else begin
            mode_new = MODE_KEEP;
            u_new    = 32'(hv);
        end
    end

    logic [32:0] red_sub;
    logic [2:0]  red_k;
    logic [24:0] h_fin;
    always_comb begin
        red_k   = 3'(RED_STEPS - 1) - cmd.iter[2:0];
        red_sub = {8'd0, DEG360} << red_k;
        unique case (mode_reg)
            MODE_HIGH: h_fin = 25'(u_reg + 32'd1);
            MODE_LOW:  h_fin = 25'({7'd0, DEG360} - 32'd1 - u_reg);
            default:   h_fin = 25'(u_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_min_reg <= -16'sd1024;
            speed_max_reg <= 15'd2560;
            steer_min_reg <= -16'sd3840;
            steer_max_reg <= 15'd3840;
            x_pos_reg     <= '0;
            z_pos_reg     <= '0;
            heading_reg   <= '0;
            travelled_reg <= '0;
            m_valid_reg   <= 1'b0;
            mode_reg      <= MODE_KEEP;
            neg_reg       <= 1'b0;
        end else begin
            if (cfg_valid) begin
                priority case (cfg_index)
                    REG_SPEED_MIN: speed_min_reg <= cfg_data;
                    REG_SPEED_MAX: speed_max_reg <= cfg_data[14:0];
                    REG_STEER_MIN: steer_min_reg <= cfg_data;
                    REG_STEER_MAX: steer_max_reg <= cfg_data[14:0];
                    default: ;
                endcase
            end
            unique case (cmd.op)
                OP_LOAD: begin
                    spd_reg <= spd_c[15:0];
                    str_reg <= str_c[15:0];
                    dt_reg  <= s_time_step;
                    cx_reg  <= CORDIC_GAIN;
                    cy_reg  <= '0;
                    ca_reg  <= af;
                    neg_reg <= fneg;
                end
                OP_SD: p_reg <= prod;
                OP_CORD: begin
                    sd_reg <= p_reg[32:0];
                    if (!ca_reg[26]) begin
                        cx_reg <= cx_reg - ys;
                        cy_reg <= cy_reg + xs;
                        ca_reg <= ca_reg - atn;
                    end else begin
                        cx_reg <= cx_reg + ys;
                        cy_reg <= cy_reg - xs;
                        ca_reg <= ca_reg + atn;
                    end
                end
                OP_X0: p_reg <= prod;
                OP_X1: begin
                    ax_reg <= 68'(p_reg);
                    p_reg  <= prod;
                end
                OP_Z0: begin
                    ax_reg <= ax_reg + (68'(p_reg) <<< 16);
                    p_reg  <= prod;
                end
                OP_Z1: begin
                    az_reg <= 68'(p_reg);
                    p_reg  <= prod;
                end
                OP_DH: begin
                    az_reg <= az_reg + (68'(p_reg) <<< 16);
                    p_reg  <= prod;
                end
                OP_HSUM: begin
                    x_pos_reg     <= sat32(xsum);
                    z_pos_reg     <= sat32(zsum);
                    travelled_reg <= sat32(dsum);
                    u_reg         <= u_new;
                    mode_reg      <= mode_new;
                    if (spd_dead) spd_reg <= '0;
                    if (str_dead) str_reg <= '0;
                end
                OP_RED: begin
                    if (mode_reg != MODE_KEEP && {1'b0, u_reg} >= red_sub) begin
                        u_reg <= 32'({1'b0, u_reg} - red_sub);
                    end
                end
                default: ;
            endcase
            if (cmd.op == OP_DONE) begin
                heading_reg   <= h_fin;
                m_valid_reg   <= 1'b1;
                m_pos_x       <= x_pos_reg;
                m_pos_z       <= z_pos_reg;
                m_heading_out <= h_fin;
                m_dist_out    <= travelled_reg;
                m_speed_out   <= spd_reg;
                m_steer_out   <= str_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        heading_reg <= DEG360)
        else $error("heading left 0..360");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.op == OP_DONE))
        else $error("result beat raised outside completion");

endmodule

### hdl/vehicle_kinematic_step.sv
// Top level of the vehicle kinematic step: one Euler step of a unicycle model per input beat.
// Depends on vks_pkg, vks_ctrl and vks_dp.
//
//   channel  direction  handshake           payload
//   s_       in         s_valid/s_ready     speed_cmd, steer_cmd, time_step
//   m_       out        m_valid/m_ready     pos_x, pos_z, heading_out, dist_out,
//                                           speed_out, steer_out
//   cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// Between acceptance and the next possible acceptance a beat runs 20 CORDIC
// iterations, six passes through the shared multiplier and eight heading-reduction steps.
// When the result appears, s_ready rises again in the same cycle.
// A stalled result holds the sequencer in its last step until the output register is free.
// aresetn is synchronous; it clears position, heading, distance and loads the default limits.
module vehicle_kinematic_step (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_speed_cmd,
    input  logic signed [15:0] s_steer_cmd,
    input  logic [15:0]        s_time_step,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_z,
    output logic [24:0]        m_heading_out,
    output logic signed [31:0] m_dist_out,
    output logic signed [15:0] m_speed_out,
    output logic signed [15:0] m_steer_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import vks_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    vks_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    vks_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_speed_cmd   (s_speed_cmd),
        .s_steer_cmd   (s_steer_cmd),
        .s_time_step   (s_time_step),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pos_x       (m_pos_x),
        .m_pos_z       (m_pos_z),
        .m_heading_out (m_heading_out),
        .m_dist_out    (m_dist_out),
        .m_speed_out   (m_speed_out),
        .m_steer_out   (m_steer_out)
    );

endmodule
